/* rtl/core/rfgl_pkg.sv */
package rfgl_pkg;

   localparam int TASK_ID_BITS_DEF   = 8;
   localparam int MAX_NEST_DEPTH_DEF = 255;

   localparam int TASK_W   = 8;
   localparam int DEPTH_W  = 8;
   localparam int STATUS_W = 3;
   localparam int OWNER_W  = 2;
   localparam int ACTION_W = 2;
   localparam int ADDR_W   = 32;
   localparam int CSR_W    = 32;
   localparam int CSR_IDX_W = 1;

   localparam logic [ACTION_W-1:0] ACT_LOCK   = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_UNLOCK = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_CHECK  = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
   localparam logic [STATUS_W-1:0] ST_INVALID    = 3'd1;
   localparam logic [STATUS_W-1:0] ST_READ_ONLY  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_BUSY       = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOT_HOLDER = 3'd4;
   localparam logic [STATUS_W-1:0] ST_DEPTH_FULL = 3'd5;

   localparam logic [OWNER_W-1:0] OWNER_NONE = 2'd0;
   localparam logic [OWNER_W-1:0] OWNER_DATA = 2'd1;
   localparam logic [OWNER_W-1:0] OWNER_BOOT = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_BASE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_SIZE = 1'b1;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [TASK_W-1:0]   task_id;
      logic                in_interrupt;
      logic [OWNER_W-1:0]  owner_class;
      logic                want_write;
      logic [ADDR_W-1:0]   address;
      logic [ADDR_W-1:0]   length;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                authorized;
      logic [DEPTH_W-1:0]  depth_now;
   } rsp_type;

endpackage

/* rtl/core/rfgl_req_reg.sv */
module rfgl_req_reg (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  rfgl_pkg::req_type in_data,
   input  logic             advance,
   output logic             out_valid,
   output rfgl_pkg::req_type out_data
);

   logic              valid_ff, valid_in;
   rfgl_pkg::req_type data_ff, data_in;

   assign in_ready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
      if (in_valid && in_ready) begin
         data_in = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

/* rtl/core/rfgl_engine.sv */
module rfgl_engine #(
   parameter int TASK_ID_BITS   = rfgl_pkg::TASK_ID_BITS_DEF,
   parameter int MAX_NEST_DEPTH = rfgl_pkg::MAX_NEST_DEPTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             fire,
   input  rfgl_pkg::req_type                req,
   input  logic                             csr_we,
   input  logic [rfgl_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rfgl_pkg::CSR_W-1:0]       csr_wdata,
   output rfgl_pkg::rsp_type                rsp
);

   localparam int TW = (TASK_ID_BITS > rfgl_pkg::TASK_W) ? rfgl_pkg::TASK_W : TASK_ID_BITS;
   localparam int DEPTH_LIMIT = (MAX_NEST_DEPTH > 255) ? 255 : MAX_NEST_DEPTH;
   localparam logic [rfgl_pkg::DEPTH_W-1:0] LIMIT = rfgl_pkg::DEPTH_W'(DEPTH_LIMIT);

   logic [rfgl_pkg::ADDR_W-1:0]  base_ff, size_ff;
   logic                         held_ff, held_in;
   logic [TW-1:0]                holder_ff, holder_in;
   logic [rfgl_pkg::OWNER_W-1:0] owner_ff, owner_in;
   logic [rfgl_pkg::DEPTH_W-1:0] nest_ff, nest_in;

   logic [TW-1:0]               task_m;
   logic                        mine;
   logic [rfgl_pkg::ADDR_W-1:0] off;
   logic                        in_win;

   assign task_m = req.task_id[TW-1:0];
   assign mine   = held_ff && (holder_ff == task_m);
   assign off    = req.address - base_ff;
   assign in_win = (req.length != '0) && (req.address >= base_ff) && (off < size_ff)
                   && (req.length <= (size_ff - off));

   always_comb begin
      held_in            = held_ff;
      holder_in          = holder_ff;
      owner_in           = owner_ff;
      nest_in            = nest_ff;
      rsp.status         = rfgl_pkg::ST_OK;
      rsp.authorized     = 1'b0;
      case (req.action)
         rfgl_pkg::ACT_LOCK: begin
            if (req.in_interrupt || (req.owner_class != rfgl_pkg::OWNER_DATA &&
                                     req.owner_class != rfgl_pkg::OWNER_BOOT)) begin
               rsp.status = rfgl_pkg::ST_INVALID;
            end else if (mine && owner_ff == req.owner_class && nest_ff != '0) begin
               if (nest_ff >= LIMIT) begin
                  rsp.status = rfgl_pkg::ST_DEPTH_FULL;
               end else begin
                  nest_in = nest_ff + 1'b1;
               end
            end else if (req.want_write && req.owner_class == rfgl_pkg::OWNER_BOOT) begin
               rsp.status = rfgl_pkg::ST_READ_ONLY;
            end else if (held_ff) begin
               rsp.status = rfgl_pkg::ST_BUSY;
            end else begin
               held_in   = 1'b1;
               holder_in = task_m;
               owner_in  = req.want_write ? req.owner_class : rfgl_pkg::OWNER_NONE;
               nest_in   = rfgl_pkg::DEPTH_W'(1);
            end
         end
         rfgl_pkg::ACT_UNLOCK: begin
            if (req.in_interrupt) begin
               rsp.status = rfgl_pkg::ST_INVALID;
            end else if (!mine || nest_ff == '0) begin
               rsp.status = rfgl_pkg::ST_NOT_HOLDER;
            end else if (nest_ff > rfgl_pkg::DEPTH_W'(1)) begin
               nest_in = nest_ff - 1'b1;
            end else begin
               held_in   = 1'b0;
               holder_in = '0;
               owner_in  = rfgl_pkg::OWNER_NONE;
               nest_in   = '0;
            end
         end
         rfgl_pkg::ACT_CHECK: begin
            rsp.authorized = !req.in_interrupt && mine &&
                             (owner_ff == rfgl_pkg::OWNER_DATA) && in_win;
         end
         default: begin
            rsp.status = rfgl_pkg::ST_INVALID;
         end
      endcase
      rsp.depth_now = nest_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff   <= '0;
         size_ff   <= '0;
         held_ff   <= 1'b0;
         holder_ff <= '0;
         owner_ff  <= rfgl_pkg::OWNER_NONE;
         nest_ff   <= '0;
      end else begin
         if (csr_we && csr_index == rfgl_pkg::CSR_WINDOW_BASE) begin
            base_ff <= csr_wdata;
         end
         if (csr_we && csr_index == rfgl_pkg::CSR_WINDOW_SIZE) begin
            size_ff <= csr_wdata;
         end
         if (fire) begin
            held_ff   <= held_in;
            holder_ff <= holder_in;
            owner_ff  <= owner_in;
            nest_ff   <= nest_in;
         end
      end
   end

endmodule

/* rtl/core/rfgl_rsp_reg.sv */
module rfgl_rsp_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  rfgl_pkg::rsp_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output rfgl_pkg::rsp_type out_data
);

   logic              valid_ff, valid_in;
   rfgl_pkg::rsp_type data_ff, data_in;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
      if (in_valid && in_ready) begin
         data_in = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

/* rtl/core/recursive_flash_guard_lock_unit.sv */
// Recursive flash guard lock: hardware semaphore with nesting and a write window.
// Request channel (req_*): valid/ready; one lock, unlock or write check per
// transfer. Response channel (rsp_*): valid/ready; exactly one response per
// request, in request order, with status, authorized and the nest depth after
// the request.
// Configuration (csr_*): csr_we writes csr_wdata to window_base (index 0) or
// window_size (index 1) in the same cycle; write only while no request is
// in flight.
// Path: a request is registered in the request register at its transfer; it is
// then decided and its response registered when the response register is free.
// Throughput: one request per cycle while rsp_ready stays high; the lock state
// update is a single register stage, so each request sees the state left by
// the one before. Stall: when rsp_ready is low the response register holds;
// the request register still takes one request if empty, then req_ready drops.
// Reset: lock free, depth zero, window base and size zero, both channels empty.
module recursive_flash_guard_lock_unit #(
   parameter int TASK_ID_BITS   = rfgl_pkg::TASK_ID_BITS_DEF,
   parameter int MAX_NEST_DEPTH = rfgl_pkg::MAX_NEST_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [rfgl_pkg::ACTION_W-1:0]   req_action,
   input  logic [rfgl_pkg::TASK_W-1:0]     req_task_id,
   input  logic                            req_in_interrupt,
   input  logic [rfgl_pkg::OWNER_W-1:0]    req_owner_class,
   input  logic                            req_want_write,
   input  logic [rfgl_pkg::ADDR_W-1:0]     req_address,
   input  logic [rfgl_pkg::ADDR_W-1:0]     req_length,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [rfgl_pkg::STATUS_W-1:0]   rsp_status,
   output logic                            rsp_authorized,
   output logic [rfgl_pkg::DEPTH_W-1:0]    rsp_depth_now,
   input  logic                            csr_we,
   input  logic [rfgl_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rfgl_pkg::CSR_W-1:0]      csr_wdata
);

   rfgl_pkg::req_type req_in, req_q;
   rfgl_pkg::rsp_type rsp_d, rsp_q;
   logic              s1_valid, s2_ready, advance;

   assign req_in.action       = req_action;
   assign req_in.task_id      = req_task_id;
   assign req_in.in_interrupt = req_in_interrupt;
   assign req_in.owner_class  = req_owner_class;
   assign req_in.want_write   = req_want_write;
   assign req_in.address      = req_address;
   assign req_in.length       = req_length;

   assign advance = s1_valid && s2_ready;

   rfgl_req_reg u_req_reg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_in),
      .advance   (advance),
      .out_valid (s1_valid),
      .out_data  (req_q)
   );

   rfgl_engine #(
      .TASK_ID_BITS   (TASK_ID_BITS),
      .MAX_NEST_DEPTH (MAX_NEST_DEPTH)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .fire      (advance),
      .req       (req_q),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp       (rsp_d)
   );

   rfgl_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_ready  (s2_ready),
      .in_data   (rsp_d),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_q)
   );

   assign rsp_status     = rsp_q.status;
   assign rsp_authorized = rsp_q.authorized;
   assign rsp_depth_now  = rsp_q.depth_now;

endmodule

/* sim/testbench.sv */
`timescale 1ns / 100ps

module testbench;

   localparam logic [rfgl_pkg::ACTION_W-1:0] ACT_SPARE     = 2'd3;
   localparam logic [rfgl_pkg::OWNER_W-1:0]  OWNER_UNKNOWN = 2'd3;
   localparam int NEST_LIMIT = (rfgl_pkg::MAX_NEST_DEPTH_DEF > 255) ? 255 :
                               rfgl_pkg::MAX_NEST_DEPTH_DEF;
   localparam int MAX_GAP    = 8;

   class lock_scoreboard_type;
      bit                                held;
      logic [rfgl_pkg::TASK_W-1:0]       holder;
      logic [rfgl_pkg::OWNER_W-1:0]      write_owner;
      logic [rfgl_pkg::DEPTH_W-1:0]      depth;
      logic [rfgl_pkg::CSR_W-1:0]        win_base;
      logic [rfgl_pkg::CSR_W-1:0]        win_size;
      rfgl_pkg::rsp_type                 due_responses[$];
      int                                mismatch_count;

      function new();
         held = 1'b0;
         holder = '0;
         write_owner = rfgl_pkg::OWNER_NONE;
         depth = '0;
         win_base = '0;
         win_size = '0;
         mismatch_count = 0;
      endfunction

      function void set_window(logic [rfgl_pkg::CSR_W-1:0] b, logic [rfgl_pkg::CSR_W-1:0] s);
         win_base = b;
         win_size = s;
      endfunction

      function bit in_window(logic [rfgl_pkg::ADDR_W-1:0] a, logic [rfgl_pkg::ADDR_W-1:0] l);
         logic [rfgl_pkg::ADDR_W-1:0] off;
         if (l == 0 || a < win_base) return 1'b0;
         off = a - win_base;
         return (off < win_size) && (l <= win_size - off);
      endfunction

      function int pending();
         return due_responses.size();
      endfunction

      // lock state update for one accepted request
      function void note_request(rfgl_pkg::req_type r);
         rfgl_pkg::rsp_type e;
         bit                mine;
         e = '0;
         e.status = rfgl_pkg::ST_OK;
         mine = held && (holder == r.task_id);
         case (r.action)
            rfgl_pkg::ACT_LOCK: begin
               if (r.in_interrupt || (r.owner_class != rfgl_pkg::OWNER_DATA &&
                                      r.owner_class != rfgl_pkg::OWNER_BOOT)) begin
                  e.status = rfgl_pkg::ST_INVALID;
               end else if (mine && write_owner == r.owner_class && depth != 0) begin
                  if (int'(depth) >= NEST_LIMIT) e.status = rfgl_pkg::ST_DEPTH_FULL;
                  else depth = depth + 1'b1;
               end else if (r.want_write && r.owner_class == rfgl_pkg::OWNER_BOOT) begin
                  e.status = rfgl_pkg::ST_READ_ONLY;
               end else if (held) begin
                  e.status = rfgl_pkg::ST_BUSY;
               end else begin
                  held = 1'b1;
                  holder = r.task_id;
                  write_owner = r.want_write ? r.owner_class : rfgl_pkg::OWNER_NONE;
                  depth = rfgl_pkg::DEPTH_W'(1);
               end
            end
            rfgl_pkg::ACT_UNLOCK: begin
               if (r.in_interrupt) begin
                  e.status = rfgl_pkg::ST_INVALID;
               end else if (!mine || depth == 0) begin
                  e.status = rfgl_pkg::ST_NOT_HOLDER;
               end else if (depth > 1) begin
                  depth = depth - 1'b1;
               end else begin
                  held = 1'b0;
                  holder = '0;
                  write_owner = rfgl_pkg::OWNER_NONE;
                  depth = '0;
               end
            end
            rfgl_pkg::ACT_CHECK: begin
               e.authorized = !r.in_interrupt && mine &&
                              write_owner == rfgl_pkg::OWNER_DATA &&
                              in_window(r.address, r.length);
            end
            default: e.status = rfgl_pkg::ST_INVALID;
         endcase
         e.depth_now = depth;
         due_responses.push_back(e);
      endfunction

      task report(string msg);
         $display("mismatch at %0t: %s", $realtime, msg);
         mismatch_count++;
      endtask

      task check_response(logic [rfgl_pkg::STATUS_W-1:0] st, logic auth,
                          logic [rfgl_pkg::DEPTH_W-1:0] dn);
         rfgl_pkg::rsp_type e;
         if (due_responses.size() == 0) begin
            report($sformatf("response with none outstanding (status %0d)", st));
            return;
         end
         e = due_responses.pop_front();
         if (st !== e.status)
            report($sformatf("status %0d, expected %0d", st, e.status));
         if (auth !== e.authorized)
            report($sformatf("authorized %0b, expected %0b", auth, e.authorized));
         if (dn !== e.depth_now)
            report($sformatf("depth_now %0d, expected %0d", dn, e.depth_now));
      endtask
   endclass

   logic                              clock = 1'b0;
   logic                              reset;
   logic                              req_valid;
   logic                              req_ready;
   logic [rfgl_pkg::ACTION_W-1:0]     req_action;
   logic [rfgl_pkg::TASK_W-1:0]       req_task_id;
   logic                              req_in_interrupt;
   logic [rfgl_pkg::OWNER_W-1:0]      req_owner_class;
   logic                              req_want_write;
   logic [rfgl_pkg::ADDR_W-1:0]       req_address;
   logic [rfgl_pkg::ADDR_W-1:0]       req_length;
   logic                              rsp_valid;
   logic                              rsp_ready;
   logic [rfgl_pkg::STATUS_W-1:0]     rsp_status;
   logic                              rsp_authorized;
   logic [rfgl_pkg::DEPTH_W-1:0]      rsp_depth_now;
   logic                              csr_we;
   logic [rfgl_pkg::CSR_IDX_W-1:0]    csr_index;
   logic [rfgl_pkg::CSR_W-1:0]        csr_wdata;

   lock_scoreboard_type sb;
   int send_idle;
   int recv_stall;
   int sent;

   recursive_flash_guard_lock_unit DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_action       (req_action),
      .req_task_id      (req_task_id),
      .req_in_interrupt (req_in_interrupt),
      .req_owner_class  (req_owner_class),
      .req_want_write   (req_want_write),
      .req_address      (req_address),
      .req_length       (req_length),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_authorized   (rsp_authorized),
      .rsp_depth_now    (rsp_depth_now),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("status: fail");
      $finish;
   end

   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ready <= ($urandom_range(99, 0) >= recv_stall);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready)
         sb.check_response(rsp_status, rsp_authorized, rsp_depth_now);
   end

   function automatic rfgl_pkg::req_type make_req(
         logic [rfgl_pkg::ACTION_W-1:0] act, logic [rfgl_pkg::TASK_W-1:0] tid,
         logic irq, logic [rfgl_pkg::OWNER_W-1:0] own, logic wr,
         logic [rfgl_pkg::ADDR_W-1:0] a, logic [rfgl_pkg::ADDR_W-1:0] l);
      rfgl_pkg::req_type r;
      r.action = act;
      r.task_id = tid;
      r.in_interrupt = irq;
      r.owner_class = own;
      r.want_write = wr;
      r.address = a;
      r.length = l;
      return r;
   endfunction

   function automatic logic rand_bit();
      return 1'($urandom_range(1, 0));
   endfunction

   function automatic logic [rfgl_pkg::OWNER_W-1:0] rand_owner();
      return rfgl_pkg::OWNER_W'($urandom_range(3, 0));
   endfunction

   function automatic logic [rfgl_pkg::ACTION_W-1:0] rand_action(int unsigned hi);
      return rfgl_pkg::ACTION_W'($urandom_range(hi, 0));
   endfunction

   function automatic logic [rfgl_pkg::TASK_W-1:0] rand_task();
      return rfgl_pkg::TASK_W'($urandom);
   endfunction

   function automatic int gap_len(int pct);
      int n;
      n = 0;
      while (n < MAX_GAP && $urandom_range(99, 0) < pct) n++;
      return n;
   endfunction

   // entered and left at a falling edge; valid stays high after the transfer
   task automatic push_request(input rfgl_pkg::req_type r);
      int gap;
      gap = gap_len(send_idle);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_action       <= r.action;
      req_task_id      <= r.task_id;
      req_in_interrupt <= r.in_interrupt;
      req_owner_class  <= r.owner_class;
      req_want_write   <= r.want_write;
      req_address      <= r.address;
      req_length       <= r.length;
      do @(posedge clock); while (req_ready !== 1'b1);
      sb.note_request(r);
      sent++;
      @(negedge clock);
   endtask

   task automatic quiesce();
      req_valid <= 1'b0;
      @(negedge clock);
      while (sb.pending() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_window(input logic [rfgl_pkg::CSR_W-1:0] b,
                               input logic [rfgl_pkg::CSR_W-1:0] s);
      csr_we    <= 1'b1;
      csr_index <= rfgl_pkg::CSR_WINDOW_BASE;
      csr_wdata <= b;
      @(negedge clock);
      csr_index <= rfgl_pkg::CSR_WINDOW_SIZE;
      csr_wdata <= s;
      @(negedge clock);
      csr_we <= 1'b0;
      sb.set_window(b, s);
   endtask

   // ranges clustered on the window edges
   task automatic pick_range(output logic [rfgl_pkg::ADDR_W-1:0] a,
                             output logic [rfgl_pkg::ADDR_W-1:0] l);
      logic [rfgl_pkg::ADDR_W-1:0] off;
      off = (sb.win_size == 0) ? '0 : $urandom_range(sb.win_size - 1, 0);
      a = sb.win_base + off;
      case ($urandom_range(6, 0))
         0, 1: l = (sb.win_size == 0) ? 1 : $urandom_range(sb.win_size - off, 1);
         2: l = sb.win_size - off;
         3: l = sb.win_size - off + 1;
         4: begin
            a = sb.win_base - $urandom_range(4, 1);
            l = $urandom_range(16, 1);
         end
         5: begin
            a = sb.win_base + sb.win_size;
            l = 1;
         end
         default: begin
            a = $urandom;
            l = $urandom_range(1, 0) ? '0 : $urandom;
         end
      endcase
   endtask

   task automatic push_noise();
      push_request(make_req(rand_action(3), rand_task(), rand_bit(), rand_owner(),
                            rand_bit(), $urandom, $urandom));
   endtask

   task automatic run_session();
      logic [rfgl_pkg::TASK_W-1:0]   t;
      logic [rfgl_pkg::TASK_W-1:0]   other;
      logic [rfgl_pkg::OWNER_W-1:0]  own;
      logic                          wr;
      logic [rfgl_pkg::ADDR_W-1:0]   a;
      logic [rfgl_pkg::ADDR_W-1:0]   l;
      int                            n;
      while (sb.held)
         push_request(make_req(rfgl_pkg::ACT_UNLOCK, sb.holder, 1'b0, rfgl_pkg::OWNER_NONE,
                               1'b0, $urandom, $urandom));
      t = rand_task();
      own = ($urandom_range(99, 0) < 75) ? rfgl_pkg::OWNER_DATA : rfgl_pkg::OWNER_BOOT;
      wr = ($urandom_range(99, 0) < 80);
      push_request(make_req(rfgl_pkg::ACT_LOCK, t, 1'b0, own, wr, $urandom, $urandom));
      n = $urandom_range(10, 1);
      repeat (n) begin
         pick_range(a, l);
         other = t + rfgl_pkg::TASK_W'($urandom_range(255, 1));
         case ($urandom_range(9, 0))
            0, 1: push_request(make_req(rfgl_pkg::ACT_LOCK, t, 1'b0, own, rand_bit(), a, l));
            2, 3, 4, 5: push_request(make_req(rfgl_pkg::ACT_CHECK, t, 1'b0, rand_owner(),
                                              rand_bit(), a, l));
            6: push_request(make_req(rand_action(2), other, 1'b0, rand_owner(),
                                     rand_bit(), a, l));
            7: push_request(make_req(rand_action(2), t, 1'b1, own, rand_bit(), a, l));
            8: push_request(make_req(rfgl_pkg::ACT_UNLOCK, t, 1'b0, own, wr, a, l));
            default: push_request(make_req(rfgl_pkg::ACT_LOCK, t, 1'b0, rand_owner(),
                                           rand_bit(), a, l));
         endcase
      end
      if ($urandom_range(99, 0) < 90)
         while (sb.held && sb.holder == t)
            push_request(make_req(rfgl_pkg::ACT_UNLOCK, t, 1'b0, own, wr,
                                  $urandom, $urandom));
   endtask

   task automatic run_random(input int count);
      int target;
      target = sent + count;
      while (sent < target) begin
         if ($urandom_range(99, 0) < 80) run_session();
         else push_noise();
      end
   endtask

   task automatic run_directed();
      push_request(make_req(rfgl_pkg::ACT_CHECK, 8'd5, 1'b0, rfgl_pkg::OWNER_DATA, 1'b1,
                            32'h1000, 32'h10));
      push_request(make_req(rfgl_pkg::ACT_UNLOCK, 8'd5, 1'b0, rfgl_pkg::OWNER_DATA, 1'b0,
                            32'h0, 32'h0));
      push_request(make_req(rfgl_pkg::ACT_LOCK, 8'd5, 1'b1, rfgl_pkg::OWNER_DATA, 1'b1,
                            32'h0, 32'h0));
      push_request(make_req(rfgl_pkg::ACT_LOCK, 8'd5, 1'b0, rfgl_pkg::OWNER_NONE, 1'b1,
                            32'h0, 32'h0));
      push_request(make_req(rfgl_pkg::ACT_LOCK, 8'd5, 1'b0, OWNER_UNKNOWN, 1'b1,
                            32'h0, 32'h0));
      push_request(make_req(rfgl_pkg::ACT_LOCK, 8'd5, 1'b0, rfgl_pkg::OWNER_BOOT, 1'b1,
                            32'h0, 32'h0));
      push_request(make_req(ACT_SPARE, 8'd5, 1'b0, rfgl_pkg::OWNER_DATA, 1'b1,
                            32'h1000, 32'h1));
      push_request(make_req(rfgl_pkg::ACT_LOCK, 8'd5, 1'b0, rfgl_pkg::OWNER_DATA, 1'b1,
                            32'h0, 32'h0));
      push_request(make_req(rfgl_pkg::ACT_LOCK, 8'd5, 1'b0, rfgl_pkg::OWNER_DATA, 1'b1,
                            32'h0, 32'h0));
      push_request(make_req(rfgl_pkg::ACT_LOCK, 8'd5, 1'b0, rfgl_pkg::OWNER_BOOT, 1'b1,
                            32'h0, 32'h0));
      push_request(make_req(rfgl_pkg::ACT_LOCK, 8'd5, 1'b0, rfgl_pkg::OWNER_DATA, 1'b0,
                            32'h0, 32'h0));
      push_request(make_req(rfgl_pkg::ACT_LOCK, 8'd255, 1'b0, rfgl_pkg::OWNER_DATA, 1'b1,
                            32'h0, 32'h0));
      push_request(make_req(rfgl_pkg::ACT_CHECK, 8'd5, 1'b0, rfgl_pkg::OWNER_DATA, 1'b0,
                            32'h1000, 32'h100));
      push_request(make_req(rfgl_pkg::ACT_CHECK, 8'd5, 1'b0, rfgl_pkg::OWNER_DATA, 1'b0,
                            32'h10ff, 32'h1));
      push_request(make_req(rfgl_pkg::ACT_CHECK, 8'd5, 1'b0, rfgl_pkg::OWNER_DATA, 1'b0,
                            32'h10ff, 32'h2));
      push_request(make_req(rfgl_pkg::ACT_CHECK, 8'd5, 1'b0, rfgl_pkg::OWNER_DATA, 1'b0,
                            32'h0fff, 32'h1));
      push_request(make_req(rfgl_pkg::ACT_CHECK, 8'd5, 1'b0, rfgl_pkg::OWNER_DATA, 1'b0,
                            32'h1000, 32'h0));
      push_request(make_req(rfgl_pkg::ACT_CHECK, 8'd5, 1'b0, rfgl_pkg::OWNER_DATA, 1'b0,
                            32'hffff_ffff, 32'hffff_ffff));
      push_request(make_req(rfgl_pkg::ACT_CHECK, 8'd5, 1'b1, rfgl_pkg::OWNER_DATA, 1'b0,
                            32'h1000, 32'h10));
      push_request(make_req(rfgl_pkg::ACT_CHECK, 8'd255, 1'b0, rfgl_pkg::OWNER_DATA, 1'b0,
                            32'h1000, 32'h10));
      push_request(make_req(rfgl_pkg::ACT_UNLOCK, 8'd255, 1'b0, rfgl_pkg::OWNER_DATA, 1'b0,
                            32'h0, 32'h0));
      push_request(make_req(rfgl_pkg::ACT_UNLOCK, 8'd5, 1'b1, rfgl_pkg::OWNER_DATA, 1'b0,
                            32'h0, 32'h0));
      repeat (3)
         push_request(make_req(rfgl_pkg::ACT_UNLOCK, 8'd5, 1'b0, rfgl_pkg::OWNER_DATA, 1'b0,
                               32'h0, 32'h0));
      // read lock: holder asking again is busy
      push_request(make_req(rfgl_pkg::ACT_LOCK, 8'd0, 1'b0, rfgl_pkg::OWNER_BOOT, 1'b0,
                            32'h0, 32'h0));
      push_request(make_req(rfgl_pkg::ACT_LOCK, 8'd0, 1'b0, rfgl_pkg::OWNER_BOOT, 1'b0,
                            32'h0, 32'h0));
      push_request(make_req(rfgl_pkg::ACT_UNLOCK, 8'd0, 1'b0, rfgl_pkg::OWNER_BOOT, 1'b0,
                            32'h0, 32'h0));
   endtask

   // nest up to the limit, one more, then unwind
   task automatic run_saturation();
      repeat (NEST_LIMIT + 1)
         push_request(make_req(rfgl_pkg::ACT_LOCK, 8'd0, 1'b0, rfgl_pkg::OWNER_DATA, 1'b1,
                               $urandom, $urandom));
      push_request(make_req(rfgl_pkg::ACT_CHECK, 8'd0, 1'b0, rfgl_pkg::OWNER_DATA, 1'b0,
                            32'h0, 32'hffff_ffff));
      repeat (NEST_LIMIT)
         push_request(make_req(rfgl_pkg::ACT_UNLOCK, 8'd0, 1'b0, rfgl_pkg::OWNER_DATA, 1'b0,
                               $urandom, $urandom));
   endtask

   initial begin
      logic [rfgl_pkg::CSR_W-1:0] edge_base[4];
      logic [rfgl_pkg::CSR_W-1:0] edge_size[4];
      int                         idle_send[4];
      int                         idle_recv[4];
      edge_base = '{32'hffff_ff00, 32'h0, 32'hffff_ffff, 32'h0000_0000};
      edge_size = '{32'h0000_0100, 32'h0, 32'hffff_ffff, 32'h0000_0001};
      idle_send = '{0, 72, 0, 13};
      idle_recv = '{0, 0, 72, 13};
      sb = new();
      sent = 0;
      send_idle = 0;
      recv_stall = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_action = rfgl_pkg::ACT_LOCK;
      req_task_id = '0;
      req_in_interrupt = 1'b0;
      req_owner_class = rfgl_pkg::OWNER_NONE;
      req_want_write = 1'b0;
      req_address = '0;
      req_length = '0;
      csr_we = 1'b0;
      csr_index = rfgl_pkg::CSR_WINDOW_BASE;
      csr_wdata = '0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      write_window(32'h0000_1000, 32'h0000_0100);
      run_directed();
      quiesce();

      send_idle = 13;
      recv_stall = 13;
      write_window(32'h0, 32'hffff_ffff);
      run_saturation();
      quiesce();

      for (int p = 0; p < 4; p++) begin
         send_idle = idle_send[p];
         recv_stall = idle_recv[p];
         write_window($urandom, $urandom_range(4096, 1));
         run_random(12);
         quiesce();
         write_window(edge_base[p], edge_size[p]);
         run_random(12);
         quiesce();
      end

      if (sb.mismatch_count == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule

/* filelist.f */
rtl/core/rfgl_pkg.sv
rtl/core/rfgl_req_reg.sv
rtl/core/rfgl_engine.sv
rtl/core/rfgl_rsp_reg.sv
rtl/core/recursive_flash_guard_lock_unit.sv
sim/testbench.sv
